/* rtl/bfdh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared constants, operation codes and control types of the Bloom filter unit.
// ----------------------------------------------------------------------------
package bfdh_pkg;

   localparam int FILT_WORDS = 64;
   localparam int FILT_AW    = 6;
   localparam int KEY_WORDS  = 8;
   localparam int KEY_AW     = 3;
   localparam int LEN_W      = 7;
   localparam int MAX_PROBES = 8;

   localparam logic [LEN_W-1:0] KEY_BYTES = 7'd64;

   localparam logic [63:0] XP1 = 64'h9E3779B185EBCA87;
   localparam logic [63:0] XP2 = 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] XP3 = 64'h165667B19E3779F9;
   localparam logic [63:0] XP4 = 64'h85EBCA77C2B2AE63;
   localparam logic [63:0] XP5 = 64'h27D4EB2F165667C5;

   localparam logic [1:0] CSR_FILTER_WORDS = 2'd0;
   localparam logic [1:0] CSR_PROBE_COUNT  = 2'd1;

   localparam logic [4:0] OP_INIT   = 5'd0;
   localparam logic [4:0] OP_LANE_A = 5'd1;
   localparam logic [4:0] OP_LANE_B = 5'd2;
   localparam logic [4:0] OP_CONV   = 5'd3;
   localparam logic [4:0] OP_MRG_A  = 5'd4;
   localparam logic [4:0] OP_MRG_B  = 5'd5;
   localparam logic [4:0] OP_MRG_C  = 5'd6;
   localparam logic [4:0] OP_ADDLEN = 5'd7;
   localparam logic [4:0] OP_WRD_A  = 5'd8;
   localparam logic [4:0] OP_WRD_C  = 5'd9;
   localparam logic [4:0] OP_W4_A   = 5'd10;
   localparam logic [4:0] OP_W4_B   = 5'd11;
   localparam logic [4:0] OP_B_A    = 5'd12;
   localparam logic [4:0] OP_B_B    = 5'd13;
   localparam logic [4:0] OP_AV_A   = 5'd14;
   localparam logic [4:0] OP_AV_B   = 5'd15;
   localparam logic [4:0] OP_KEYRD  = 5'd16;
   localparam logic [4:0] OP_PRINIT = 5'd17;
   localparam logic [4:0] OP_MOD    = 5'd18;
   localparam logic [4:0] OP_PRD    = 5'd19;
   localparam logic [4:0] OP_PUPD   = 5'd20;
   localparam logic [4:0] OP_RESULT = 5'd21;

   typedef struct packed {
      logic              absorb;
      logic              start;
      logic [4:0]        op;
      logic [1:0]        lane;
      logic [KEY_AW-1:0] widx;
      logic [2:0]        bidx;
      logic              pass;
   } bfdh_cmd_type;

   typedef struct packed {
      logic             done;
      logic             ovf;
      logic [LEN_W-1:0] len;
      logic [3:0]       probes;
      logic             rsp_busy;
   } bfdh_stat_type;

   function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned r);
      return (v << r) | (v >> (64 - r));
   endfunction

endpackage
`default_nettype wire

/* rtl/bfdh_mul64.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_mul64
// Low 64 bits of a 64x64 product from three 32x32 partial products.
// ----------------------------------------------------------------------------
module bfdh_mul64
   import bfdh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             done,
   output logic [63:0]      p
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LL   = 2'd1;
   localparam logic [1:0] PH_LH   = 2'd2;
   localparam logic [1:0] PH_HL   = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic        done_ff, done_in;
   logic [63:0] a_ff, b_ff, acc_ff, acc_in;
   logic [31:0] ma, mb;
   logic [63:0] prod;

   always_comb begin
      ma = (phase_ff == PH_HL) ? a_ff[63:32] : a_ff[31:0];
      mb = (phase_ff == PH_LH) ? b_ff[63:32] : b_ff[31:0];
      prod = {32'h0, ma} * {32'h0, mb};
      phase_in = phase_ff;
      done_in = 1'b0;
      acc_in = acc_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start) phase_in = PH_LL;
         end
         PH_LL: begin
            acc_in = prod;
            phase_in = PH_LH;
         end
         PH_LH: begin
            acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
            phase_in = PH_HL;
         end
         PH_HL: begin
            acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
            phase_in = PH_IDLE;
            done_in = 1'b1;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && phase_ff == PH_IDLE) begin
         a_ff <= a;
         b_ff <= b;
      end
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign p = acc_ff;

endmodule
`default_nettype wire

/* rtl/bfdh_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_datapath
// Key buffer, hash registers, remainder unit, bit store and result register.
// ----------------------------------------------------------------------------
module bfdh_datapath
   import bfdh_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire bfdh_cmd_type  cmd,
   output bfdh_stat_type      st,
   input  wire logic          req_func,
   input  wire logic [63:0]   req_chunk,
   input  wire logic [3:0]    req_bytes,
   input  wire logic          req_last,
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_index,
   input  wire logic [6:0]    csr_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_maybe,
   output logic               rsp_status,
   output logic [31:0]        rsp_items
);

   logic [LEN_W-1:0]  len_ff;
   logic [63:0]       part_ff;
   logic              ovf_ff;
   logic [6:0]        cfg_words_ff;
   logic [3:0]        cfg_probes_ff;
   logic [31:0]       count_ff;
   logic              rsp_valid_ff;
   logic [FILT_WORDS-1:0] fvld_ff;
   logic              mbusy_ff, mdone_ff;
   logic [3:0]        mcnt_ff;

   logic [63:0]       key_mem [KEY_WORDS];
   logic [63:0]       filt_mem [FILT_WORDS];
   logic [63:0]       word_ff, h_ff, h1_ff, t_ff, p_ff, frd_ff;
   logic [63:0]       v_ff [4];
   logic [4:0]        op_ff;
   logic [1:0]        lane_ff;
   logic              all_ff, func_ff, fvld_rd_ff;
   logic [6:0]        words_ff;
   logic [3:0]        probes_ff;
   logic [59:0]       mx_ff;
   logic [6:0]        mr_ff;
   logic [FILT_AW-1:0] rem_ff;
   logic              rsp_maybe_ff, rsp_status_ff;
   logic [31:0]       rsp_items_ff;

   // chunk packing
   logic [3:0]   nb, take, fill;
   logic [6:0]   space;
   logic         drop, full;
   logic [63:0]  chunk_m;
   logic [127:0] packed_w;

   always_comb begin
      nb = (req_bytes > 4'd8) ? 4'd8 : req_bytes;
      space = KEY_BYTES - len_ff;
      drop = {3'b000, nb} > space;
      take = drop ? space[3:0] : nb;
      for (int b = 0; b < 8; b++) begin
         chunk_m[8*b +: 8] = (4'(b) < take) ? req_chunk[8*b +: 8] : 8'h00;
      end
      packed_w = {64'h0, part_ff} | ({64'h0, chunk_m} << {len_ff[2:0], 3'b000});
      fill = {1'b0, len_ff[2:0]} + take;
      full = fill[3];
   end

   // multiplier operands
   logic        mul_go, mul_done;
   logic [63:0] mul_a, mul_b, mp, seed, hfin;
   logic [7:0]  tail_byte;

   assign tail_byte = part_ff[{cmd.bidx, 3'b000} +: 8];
   assign seed = cmd.pass ? h1_ff : 64'h0;
   assign hfin = mp ^ (mp >> 32);

   always_comb begin
      mul_go = cmd.start;
      mul_a = 64'h0;
      mul_b = XP1;
      case (cmd.op)
         OP_LANE_A: begin mul_a = word_ff; mul_b = XP2; end
         OP_LANE_B: mul_a = v_ff[cmd.lane];
         OP_MRG_A:  begin mul_a = v_ff[cmd.lane]; mul_b = XP2; end
         OP_MRG_B:  mul_a = t_ff;
         OP_MRG_C:  mul_a = h_ff;
         OP_WRD_A:  begin mul_a = word_ff; mul_b = XP2; end
         OP_WRD_C:  mul_a = rotl(h_ff, 27);
         OP_W4_A:   mul_a = {32'h0, part_ff[31:0]};
         OP_W4_B:   begin mul_a = rotl(h_ff, 23); mul_b = XP2; end
         OP_B_A:    begin mul_a = {56'h0, tail_byte}; mul_b = XP5; end
         OP_B_B:    mul_a = rotl(h_ff, 11);
         OP_AV_A:   begin mul_a = h_ff ^ (h_ff >> 33); mul_b = XP2; end
         OP_AV_B:   begin mul_a = h_ff ^ (h_ff >> 29); mul_b = XP3; end
         default:   mul_go = 1'b0;
      endcase
   end

   bfdh_mul64 u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_go),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mp)
   );

   // remainder of the word index, four quotient bits a cycle
   logic [6:0]  mr_nx;
   logic [59:0] mx_nx;

   always_comb begin
      mr_nx = mr_ff;
      mx_nx = mx_ff;
      for (int j = 0; j < 4; j++) begin
         mr_nx = {mr_nx[5:0], mx_nx[59]};
         mx_nx = {mx_nx[58:0], 1'b0};
         if (mr_nx >= words_ff) mr_nx = mr_nx - words_ff;
      end
   end

   // probe and result
   logic [63:0] fword, fmask;
   logic        fbit, add_ok;
   logic [31:0] count_nx;

   always_comb begin
      fword = fvld_rd_ff ? frd_ff : 64'h0;
      fmask = 64'h1 << p_ff[5:0];
      fbit = fword[p_ff[5:0]];
      add_ok = !ovf_ff && !func_ff;
      count_nx = (add_ok && count_ff != 32'hFFFF_FFFF) ? count_ff + 32'd1 : count_ff;
   end

   logic do_result, do_pupd;
   assign do_result = cmd.start && cmd.op == OP_RESULT;
   assign do_pupd = cmd.start && cmd.op == OP_PUPD;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         part_ff <= '0;
         ovf_ff <= 1'b0;
         cfg_words_ff <= 7'd64;
         cfg_probes_ff <= 4'd1;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         fvld_ff <= '0;
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
         mcnt_ff <= '0;
      end else begin
         if (csr_we && csr_index == CSR_FILTER_WORDS) cfg_words_ff <= csr_data;
         if (csr_we && csr_index == CSR_PROBE_COUNT) cfg_probes_ff <= csr_data[3:0];
         if (cmd.absorb) begin
            len_ff <= len_ff + {3'b000, take};
            part_ff <= full ? packed_w[127:64] : packed_w[63:0];
            if (drop) ovf_ff <= 1'b1;
         end
         mdone_ff <= 1'b0;
         if (cmd.start && cmd.op == OP_MOD) begin
            mbusy_ff <= 1'b1;
            mcnt_ff <= '0;
         end else if (mbusy_ff) begin
            mcnt_ff <= mcnt_ff + 4'd1;
            if (mcnt_ff == 4'd14) begin
               mbusy_ff <= 1'b0;
               mdone_ff <= 1'b1;
            end
         end
         if (do_pupd && !func_ff) fvld_ff[rem_ff] <= 1'b1;
         if (do_result) begin
            count_ff <= count_nx;
            rsp_valid_ff <= 1'b1;
            len_ff <= '0;
            part_ff <= '0;
            ovf_ff <= 1'b0;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.absorb && full) key_mem[len_ff[5:3]] <= packed_w[63:0];
      if (cmd.absorb && req_last) begin
         func_ff <= req_func;
         words_ff <= (cfg_words_ff == 7'd0) ? 7'd1 :
                     (cfg_words_ff > 7'(FILT_WORDS)) ? 7'(FILT_WORDS) : cfg_words_ff;
         probes_ff <= (cfg_probes_ff == 4'd0) ? 4'd1 :
                      (cfg_probes_ff > 4'(MAX_PROBES)) ? 4'(MAX_PROBES) : cfg_probes_ff;
      end
      if (mul_go) begin
         op_ff <= cmd.op;
         lane_ff <= cmd.lane;
      end
      if (cmd.start) begin
         case (cmd.op)
            OP_INIT: begin
               if (len_ff >= 7'd32) begin
                  v_ff[0] <= seed + XP1 + XP2;
                  v_ff[1] <= seed + XP2;
                  v_ff[2] <= seed;
                  v_ff[3] <= seed - XP1;
               end else begin
                  h_ff <= seed + XP5;
               end
            end
            OP_CONV: h_ff <= rotl(v_ff[0], 1) + rotl(v_ff[1], 7) +
                             rotl(v_ff[2], 12) + rotl(v_ff[3], 18);
            OP_ADDLEN: h_ff <= h_ff + {57'h0, len_ff};
            OP_KEYRD: word_ff <= key_mem[cmd.widx];
            OP_PRINIT: begin
               p_ff <= h1_ff;
               all_ff <= 1'b1;
            end
            OP_MOD: begin
               mx_ff <= {2'b00, p_ff[63:6]};
               mr_ff <= '0;
            end
            OP_PRD: begin
               frd_ff <= filt_mem[rem_ff];
               fvld_rd_ff <= fvld_ff[rem_ff];
            end
            OP_PUPD: begin
               if (!func_ff) filt_mem[rem_ff] <= fword | fmask;
               else all_ff <= all_ff & fbit;
               p_ff <= p_ff + h_ff;
            end
            OP_RESULT: begin
               rsp_maybe_ff <= func_ff & all_ff & !ovf_ff;
               rsp_status_ff <= ovf_ff;
               rsp_items_ff <= count_nx;
            end
            default: ;
         endcase
      end
      if (mbusy_ff) begin
         mx_ff <= mx_nx;
         mr_ff <= mr_nx;
         if (mcnt_ff == 4'd14) rem_ff <= mr_nx[FILT_AW-1:0];
      end
      if (mul_done) begin
         case (op_ff)
            OP_LANE_A: v_ff[lane_ff] <= rotl(v_ff[lane_ff] + mp, 31);
            OP_LANE_B: v_ff[lane_ff] <= mp;
            OP_MRG_A, OP_WRD_A: t_ff <= rotl(mp, 31);
            OP_MRG_B, OP_W4_A, OP_B_A: h_ff <= h_ff ^ mp;
            OP_MRG_C, OP_WRD_C: h_ff <= mp + XP4;
            OP_W4_B: h_ff <= mp + XP3;
            OP_B_B, OP_AV_A: h_ff <= mp;
            OP_AV_B: begin
               h_ff <= hfin;
               if (!cmd.pass) h1_ff <= hfin;
            end
            default: ;
         endcase
      end
   end

   assign st.done = mul_done | mdone_ff;
   assign st.ovf = ovf_ff;
   assign st.len = len_ff;
   assign st.probes = probes_ff;
   assign st.rsp_busy = rsp_valid_ff & !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_maybe = rsp_maybe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_items = rsp_items_ff;

endmodule
`default_nettype wire

/* rtl/bfdh_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfdh_ctrl
// Sequencer of the two hash passes, the probes and the result.
// ----------------------------------------------------------------------------
module bfdh_ctrl
   import bfdh_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_last,
   output logic               req_ready,
   input  wire bfdh_stat_type st,
   output bfdh_cmd_type       cmd
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CHECK   = 5'd1;
   localparam logic [4:0] S_INIT    = 5'd2;
   localparam logic [4:0] S_FETCH_S = 5'd3;
   localparam logic [4:0] S_LANE_A  = 5'd4;
   localparam logic [4:0] S_LANE_B  = 5'd5;
   localparam logic [4:0] S_CONV    = 5'd6;
   localparam logic [4:0] S_MRG_A   = 5'd7;
   localparam logic [4:0] S_MRG_B   = 5'd8;
   localparam logic [4:0] S_MRG_C   = 5'd9;
   localparam logic [4:0] S_ADDLEN  = 5'd10;
   localparam logic [4:0] S_FETCH_W = 5'd11;
   localparam logic [4:0] S_WRD_A   = 5'd12;
   localparam logic [4:0] S_WRD_B   = 5'd13;
   localparam logic [4:0] S_WRD_C   = 5'd14;
   localparam logic [4:0] S_W4_A    = 5'd15;
   localparam logic [4:0] S_W4_B    = 5'd16;
   localparam logic [4:0] S_B_A     = 5'd17;
   localparam logic [4:0] S_B_B     = 5'd18;
   localparam logic [4:0] S_AV_A    = 5'd19;
   localparam logic [4:0] S_AV_B    = 5'd20;
   localparam logic [4:0] S_PRINIT  = 5'd21;
   localparam logic [4:0] S_MOD     = 5'd22;
   localparam logic [4:0] S_PRD     = 5'd23;
   localparam logic [4:0] S_PUPD    = 5'd24;
   localparam logic [4:0] S_RESULT  = 5'd25;

   logic [4:0] state_ff, state_in;
   logic       issued_ff, issued_in;
   logic       pass_ff, pass_in;
   logic [3:0] widx_ff, widx_in;
   logic [1:0] mlane_ff, mlane_in;
   logic [2:0] bidx_ff, bidx_in;
   logic [3:0] pidx_ff, pidx_in;

   logic [3:0] nw, stripe_words;
   logic [2:0] tail;
   logic [4:0] tail_state;

   always_comb begin
      nw = st.len[6:3];
      tail = st.len[2:0];
      stripe_words = st.len[6] ? 4'd8 : 4'd4;
      if (tail[2]) tail_state = S_W4_A;
      else if (tail != 3'd0) tail_state = S_B_A;
      else tail_state = S_AV_A;
   end

   always_comb begin
      state_in = state_ff;
      issued_in = issued_ff;
      pass_in = pass_ff;
      widx_in = widx_ff;
      mlane_in = mlane_ff;
      bidx_in = bidx_ff;
      pidx_in = pidx_ff;
      cmd = '0;
      cmd.pass = pass_ff;
      cmd.widx = widx_ff[KEY_AW-1:0];
      cmd.bidx = bidx_ff;
      cmd.lane = widx_ff[1:0];
      req_ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.absorb = req_valid;
            if (req_valid && req_last) state_in = S_CHECK;
         end
         S_CHECK: begin
            pass_in = 1'b0;
            widx_in = '0;
            state_in = st.ovf ? S_RESULT : S_INIT;
         end
         S_INIT: begin
            cmd.op = OP_INIT;
            cmd.start = 1'b1;
            widx_in = '0;
            bidx_in = '0;
            mlane_in = '0;
            state_in = (st.len >= 7'd32) ? S_FETCH_S : S_ADDLEN;
         end
         S_FETCH_S: begin
            cmd.op = OP_KEYRD;
            cmd.start = 1'b1;
            state_in = S_LANE_A;
         end
         S_LANE_A, S_LANE_B, S_MRG_A, S_MRG_B, S_MRG_C, S_WRD_A, S_WRD_B, S_WRD_C,
         S_W4_A, S_W4_B, S_B_A, S_B_B, S_AV_A, S_AV_B, S_MOD: begin
            case (state_ff)
               S_LANE_A: cmd.op = OP_LANE_A;
               S_LANE_B: cmd.op = OP_LANE_B;
               S_MRG_A:  cmd.op = OP_MRG_A;
               S_MRG_B:  cmd.op = OP_MRG_B;
               S_MRG_C:  cmd.op = OP_MRG_C;
               S_WRD_A:  cmd.op = OP_WRD_A;
               S_WRD_B:  cmd.op = OP_MRG_B;
               S_WRD_C:  cmd.op = OP_WRD_C;
               S_W4_A:   cmd.op = OP_W4_A;
               S_W4_B:   cmd.op = OP_W4_B;
               S_B_A:    cmd.op = OP_B_A;
               S_B_B:    cmd.op = OP_B_B;
               S_AV_A:   cmd.op = OP_AV_A;
               S_AV_B:   cmd.op = OP_AV_B;
               default:  cmd.op = OP_MOD;
            endcase
            if (state_ff inside {S_MRG_A, S_MRG_B, S_MRG_C}) cmd.lane = mlane_ff;
            cmd.start = !issued_ff;
            if (!issued_ff) begin
               issued_in = 1'b1;
            end else if (st.done) begin
               issued_in = 1'b0;
               case (state_ff)
                  S_LANE_A: state_in = S_LANE_B;
                  S_LANE_B: begin
                     widx_in = widx_ff + 4'd1;
                     state_in = (widx_ff + 4'd1 == stripe_words) ? S_CONV : S_FETCH_S;
                  end
                  S_MRG_A: state_in = S_MRG_B;
                  S_MRG_B: state_in = S_MRG_C;
                  S_MRG_C: begin
                     mlane_in = mlane_ff + 2'd1;
                     state_in = (mlane_ff == 2'd3) ? S_ADDLEN : S_MRG_A;
                  end
                  S_WRD_A: state_in = S_WRD_B;
                  S_WRD_B: state_in = S_WRD_C;
                  S_WRD_C: begin
                     widx_in = widx_ff + 4'd1;
                     state_in = (widx_ff + 4'd1 < nw) ? S_FETCH_W : tail_state;
                  end
                  S_W4_A: state_in = S_W4_B;
                  S_W4_B: begin
                     bidx_in = 3'd4;
                     state_in = (tail > 3'd4) ? S_B_A : S_AV_A;
                  end
                  S_B_A: state_in = S_B_B;
                  S_B_B: begin
                     bidx_in = bidx_ff + 3'd1;
                     state_in = ({1'b0, bidx_ff} + 4'd1 < {1'b0, tail}) ? S_B_A : S_AV_A;
                  end
                  S_AV_A: state_in = S_AV_B;
                  S_AV_B: begin
                     if (!pass_ff) begin
                        pass_in = 1'b1;
                        state_in = S_INIT;
                     end else begin
                        pidx_in = '0;
                        state_in = S_PRINIT;
                     end
                  end
                  default: state_in = S_PRD;
               endcase
            end
         end
         S_CONV: begin
            cmd.op = OP_CONV;
            cmd.start = 1'b1;
            state_in = S_MRG_A;
         end
         S_ADDLEN: begin
            cmd.op = OP_ADDLEN;
            cmd.start = 1'b1;
            state_in = (widx_ff < nw) ? S_FETCH_W : tail_state;
         end
         S_FETCH_W: begin
            cmd.op = OP_KEYRD;
            cmd.start = 1'b1;
            state_in = S_WRD_A;
         end
         S_PRINIT: begin
            cmd.op = OP_PRINIT;
            cmd.start = 1'b1;
            state_in = S_MOD;
         end
         S_PRD: begin
            cmd.op = OP_PRD;
            cmd.start = 1'b1;
            state_in = S_PUPD;
         end
         S_PUPD: begin
            cmd.op = OP_PUPD;
            cmd.start = 1'b1;
            pidx_in = pidx_ff + 4'd1;
            state_in = (pidx_ff + 4'd1 < st.probes) ? S_MOD : S_RESULT;
         end
         S_RESULT: begin
            cmd.op = OP_RESULT;
            if (!st.rsp_busy) begin
               cmd.start = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issued_ff <= 1'b0;
         pass_ff <= 1'b0;
         widx_ff <= '0;
         mlane_ff <= '0;
         bidx_ff <= '0;
         pidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         issued_ff <= issued_in;
         pass_ff <= pass_in;
         widx_ff <= widx_in;
         mlane_ff <= mlane_in;
         bidx_ff <= bidx_in;
         pidx_ff <= pidx_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/bloom_filter_double_hash_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_unit
// Bloom filter engine: two XXH64 passes over a buffered key, then probes.
// ----------------------------------------------------------------------------
// A key arrives on req_ as chunks of up to eight bytes; tlast marks its final
// chunk and tuser says add (0) or query (1). Chunks before the last are taken
// one a cycle. After the last chunk the request ready drops while the key is
// hashed twice and probed; one response then appears on rsp_.
// Every 64-bit product uses the shared multiplier, one product at a time, for
// each of the two passes. Each probe waits on the remainder unit at four bits
// a cycle, then does the read-modify-write of the bit store. A rejected key
// skips both passes and goes from the check state straight to the result.
// The response waits in an output register; chunks of the next key are still
// taken while it is stalled, but its final result waits until rsp_ is free.
// Reset clears the bit store (per-word valid flags), the count and the key.
// csr_ writes are always ready and take effect at the next key's last chunk.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_unit
   import bfdh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // key_chunk[63:0], chunk_bytes[67:64], zero pad
   input  wire logic        req_tlast,
   input  wire logic        req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // maybe_present[0], status[1], items_added[33:2], pad
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_data
);

   bfdh_cmd_type  cmd;
   bfdh_stat_type st;
   logic          rsp_maybe, rsp_status;
   logic [31:0]   rsp_items;

   assign csr_ready = 1'b1;

   bfdh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .st        (st),
      .cmd       (cmd)
   );

   bfdh_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_func   (req_tuser),
      .req_chunk  (req_tdata[63:0]),
      .req_bytes  (req_tdata[67:64]),
      .req_last   (req_tlast),
      .csr_we     (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_maybe  (rsp_maybe),
      .rsp_status (rsp_status),
      .rsp_items  (rsp_items)
   );

   assign rsp_tdata = {6'h00, rsp_items, rsp_status, rsp_maybe};

   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.start && cmd.op == OP_RESULT |-> !rsp_tvalid || rsp_tready)
      else $error("result loaded over a pending response");

   a_reject_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("rejected key reported present");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !st.done)
      else $error("unit completion while accepting requests");

   a_ovf_no_hash: assert property (@(posedge clock) disable iff (reset)
      st.ovf && cmd.start |-> cmd.op == OP_RESULT)
      else $error("hashing started on an overlong key");

endmodule
`default_nettype wire

/* bench/tb_bloom_filter_double_hash_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bloom_filter_double_hash_unit
// Self-checking bench for the Bloom filter unit with XXH64 double hashing.
// ----------------------------------------------------------------------------
// Keys are sent as chunked requests (adds and queries), while both filter
// registers are swept through their full range, extremes included. A local
// model of the bit store, hashing and item count predicts every response;
// responses are checked field by field in order. Flow control is exercised
// with random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_bloom_filter_double_hash_unit
   import bfdh_pkg::*;
();

   localparam int CYCLE_LIMIT = 2000000;

   typedef enum logic {FN_ADD = 1'b0, FN_QUERY = 1'b1} func_type;
   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_type;

   typedef struct packed {
      logic        maybe;
      logic        status;
      logic [31:0] count;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // key_chunk[63:0], chunk_bytes[67:64], pad
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0; // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // maybe_present[0], status[1], items_added[33:2]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_data = '0;

   bloom_filter_double_hash_unit uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // filter state
   logic [63:0] store_bits [0:FILT_WORDS-1];
   logic [7:0]  key_bytes  [0:KEY_WORDS*8-1];
   int          key_len;
   logic        key_ovf;
   logic [31:0] add_total;
   logic [6:0]  cfg_words;
   logic [3:0]  cfg_probes;
   answer_type  answer_q [$];

   // stimulus state
   logic [7:0]  new_key [0:95];
   logic [7:0]  pool    [0:63][0:63];
   int          pool_len [0:63];
   int          pool_n = 0;
   idle_type    idle_mode = IDLE_NONE;
   int          fails = 0;
   int          chunks_sent = 0;
   int          keys_sent = 0;
   int          hits = 0;
   int          rejects = 0;
   int          answers_seen = 0;
   longint      cycles = 0;
   int          l_arr_len [5] = '{1, 4, 7, 32, 64};

   function automatic logic [63:0] rotl64(input logic [63:0] v, input int r);
      return (v << r) | (v >> (64 - r));
   endfunction

   function automatic logic [63:0] mix_round(input logic [63:0] acc, input logic [63:0] in);
      logic [63:0] a;
      a = acc + in * XP2;
      a = rotl64(a, 31);
      return a * XP1;
   endfunction

   function automatic logic [63:0] key_word(input int p, input int n);
      logic [63:0] v;
      v = '0;
      for (int i = n - 1; i >= 0; i--) v = (v << 8) | key_bytes[p + i];
      return v;
   endfunction

   function automatic logic [63:0] xxh64_key(input logic [63:0] seed);
      logic [63:0] h, v1, v2, v3, v4, t;
      int pos;
      pos = 0;
      if (key_len >= 32) begin
         v1 = seed + XP1 + XP2;
         v2 = seed + XP2;
         v3 = seed;
         v4 = seed - XP1;
         while (pos + 32 <= key_len) begin
            v1 = mix_round(v1, key_word(pos, 8));
            v2 = mix_round(v2, key_word(pos + 8, 8));
            v3 = mix_round(v3, key_word(pos + 16, 8));
            v4 = mix_round(v4, key_word(pos + 24, 8));
            pos += 32;
         end
         h = rotl64(v1, 1) + rotl64(v2, 7) + rotl64(v3, 12) + rotl64(v4, 18);
         h = (h ^ mix_round(0, v1)) * XP1 + XP4;
         h = (h ^ mix_round(0, v2)) * XP1 + XP4;
         h = (h ^ mix_round(0, v3)) * XP1 + XP4;
         h = (h ^ mix_round(0, v4)) * XP1 + XP4;
      end else begin
         h = seed + XP5;
      end
      h = h + 64'(key_len);
      while (pos + 8 <= key_len) begin
         h = h ^ mix_round(0, key_word(pos, 8));
         h = rotl64(h, 27) * XP1 + XP4;
         pos += 8;
      end
      if (pos + 4 <= key_len) begin
         t = key_word(pos, 4);
         h = h ^ (t * XP1);
         h = rotl64(h, 23) * XP2 + XP3;
         pos += 4;
      end
      while (pos < key_len) begin
         t = 64'(key_bytes[pos]);
         h = h ^ (t * XP5);
         h = rotl64(h, 11) * XP1;
         pos++;
      end
      h = h ^ (h >> 33);
      h = h * XP2;
      h = h ^ (h >> 29);
      h = h * XP3;
      h = h ^ (h >> 32);
      return h;
   endfunction

   // absorb one accepted chunk; on the last chunk queue the expected answer
   task automatic absorb_chunk(input logic fn, input logic [63:0] chunk,
                               input logic [3:0] nb, input logic last);
      int n, words, probes;
      logic [63:0] h1, h2, nbits, idx;
      logic all_set;
      answer_type a;
      n = (nb > 8) ? 8 : int'(nb);
      for (int b = 0; b < n; b++) begin
         if (key_len >= KEY_WORDS * 8) begin
            key_ovf = 1'b1;
            break;
         end
         key_bytes[key_len] = chunk[8*b +: 8];
         key_len++;
      end
      if (last) begin
         a = '0;
         if (key_ovf) begin
            a.status = 1'b1;
            rejects++;
         end else begin
            words = (cfg_words == 0) ? 1 : (cfg_words > FILT_WORDS) ? FILT_WORDS : cfg_words;
            probes = (cfg_probes == 0) ? 1 :
                     (cfg_probes > MAX_PROBES) ? MAX_PROBES : cfg_probes;
            nbits = 64'(words) * 64;
            h1 = xxh64_key(64'd0);
            h2 = xxh64_key(h1);
            all_set = 1'b1;
            for (int i = 0; i < probes; i++) begin
               idx = (h1 + 64'(i) * h2) % nbits;
               if (fn == FN_ADD) store_bits[idx[11:6]][idx[5:0]] = 1'b1;
               else if (!store_bits[idx[11:6]][idx[5:0]]) all_set = 1'b0;
            end
            if (fn == FN_ADD) begin
               if (add_total != 32'hFFFF_FFFF) add_total++;
            end else begin
               a.maybe = all_set;
               if (all_set) hits++;
            end
         end
         a.count = add_total;
         answer_q.insert(answer_q.size(), a);
         key_len = 0;
         key_ovf = 1'b0;
      end
   endtask

   // one request: optional gap, then hold until accepted
   task automatic send_chunk(input logic fn, input logic [63:0] chunk,
                             input logic [3:0] nb, input logic last);
      int gap_pct;
      gap_pct = (idle_mode == IDLE_SEND) ? 66 : (idle_mode == IDLE_BOTH) ? 6 : 0;
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {4'd0, nb, chunk};
      req_tlast = last;
      req_tuser = fn;
      do @(posedge clock); while (!req_tready);
      absorb_chunk(fn, chunk, nb, last);
      chunks_sent++;
      @(negedge clock);
   endtask

   // key in new_key[0:len-1], split into chunks of random size
   task automatic send_key(input logic fn, input int len);
      int pos, remain, nb, n;
      logic [63:0] chunk;
      logic last;
      pos = 0;
      do begin
         remain = len - pos;
         nb = ($urandom_range(9) < 6) ? 8 : $urandom_range(0, 15);
         n = (nb > 8) ? 8 : nb;
         last = 1'b0;
         if (n >= remain) begin
            last = 1'b1;
            nb = (remain == 8 && nb > 8) ? nb : remain;
            n = remain;
         end
         chunk = {$urandom, $urandom};
         for (int b = 0; b < n; b++) chunk[8*b +: 8] = new_key[pos + b];
         send_chunk(last ? fn : func_type'($urandom_range(1)), chunk, 4'(nb), last);
         pos += n;
      end while (!last);
      keys_sent++;
      if (fn == FN_ADD && len <= KEY_WORDS * 8) begin
         for (int b = 0; b < len; b++) pool[pool_n % 64][b] = new_key[b];
         pool_len[pool_n % 64] = len;
         pool_n++;
      end
   endtask

   task automatic random_key(input int len);
      for (int b = 0; b < len; b++) new_key[b] = 8'($urandom);
   endtask

   task automatic wait_drained();
      while (answer_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [6:0] val);
      req_tvalid = 1'b0;
      wait_drained();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FILTER_WORDS) cfg_words = val;
      else if (idx == CSR_PROBE_COUNT) cfg_probes = val[3:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_directed();
      // defaults: whole store, single probe
      send_key(FN_QUERY, 0);
      send_key(FN_ADD, 0);
      send_key(FN_QUERY, 0);
      foreach (new_key[b]) new_key[b] = 8'hFF;
      send_key(FN_ADD, 8);
      send_key(FN_QUERY, 8);
      foreach (new_key[b]) new_key[b] = 8'h00;
      send_key(FN_ADD, 8);
      csr_write(CSR_FILTER_WORDS, 7'd1);
      csr_write(CSR_PROBE_COUNT, 7'd8);
      random_key(64);
      foreach (l_arr_len[i]) begin
         send_key(FN_ADD, l_arr_len[i]);
         send_key(FN_QUERY, l_arr_len[i]);
      end
      // too long: exactly one byte and many bytes past the buffer
      random_key(80);
      send_key(FN_ADD, 65);
      send_key(FN_QUERY, 80);
      // out-of-range register values fall back to the limits
      csr_write(CSR_FILTER_WORDS, 7'd0);
      csr_write(CSR_PROBE_COUNT, 7'd0);
      send_key(FN_ADD, 12);
      csr_write(CSR_FILTER_WORDS, 7'd127);
      csr_write(CSR_PROBE_COUNT, 7'd15);
      send_key(FN_QUERY, 12);
      send_key(FN_ADD, 33);
   endtask

   task automatic test_random(input int per_phase);
      logic fn;
      int len, sel, start;
      for (int ph = 0; ph < 8; ph++) begin
         idle_mode = idle_type'(ph % 4);
         case (ph)
            0: begin
               csr_write(CSR_FILTER_WORDS, 7'd1);
               csr_write(CSR_PROBE_COUNT, 7'd8);
            end
            1: begin
               csr_write(CSR_FILTER_WORDS, 7'd64);
               csr_write(CSR_PROBE_COUNT, 7'd1);
            end
            default: begin
               csr_write(CSR_FILTER_WORDS, 7'($urandom_range(0, 127)));
               csr_write(CSR_PROBE_COUNT, 7'($urandom_range(0, 127)));
            end
         endcase
         start = chunks_sent;
         while (chunks_sent - start < per_phase) begin
            fn = func_type'($urandom_range(1));
            sel = $urandom_range(99);
            if (fn == FN_QUERY && pool_n > 0 && sel < 55) begin
               sel = $urandom_range(((pool_n < 64) ? pool_n : 64) - 1);
               len = pool_len[sel];
               for (int b = 0; b < len; b++) new_key[b] = pool[sel][b];
            end else begin
               if (sel < 70) len = $urandom_range(0, 24);
               else if (sel < 95) len = $urandom_range(25, 64);
               else len = $urandom_range(65, 90);
               random_key(len);
            end
            send_key(fn, len);
            // in phase 5, past half its chunks, hold off after each key until everything in flight has answered
            if (ph == 5 && chunks_sent - start > per_phase / 2 && answer_q.size() != 0) begin
               req_tvalid = 1'b0;
               while (answer_q.size() != 0) @(posedge clock);
               @(negedge clock);
            end
         end
      end
      req_tvalid = 1'b0;
   endtask

   always @(negedge clock) begin
      case (idle_mode)
         IDLE_RECV: rsp_tready <= ($urandom_range(99) >= 66);
         IDLE_BOTH: rsp_tready <= ($urandom_range(99) >= 6);
         default:   rsp_tready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answers_seen++;
         if (answer_q.size() == 0) begin
            $display("%0t unexpected response %h", $time, rsp_tdata);
            fails++;
         end else begin
            want = answer_q.pop_front();
            if (rsp_tdata[0] !== want.maybe) begin
               $display("%0t maybe_present exp %0d got %0d", $time, want.maybe, rsp_tdata[0]);
               fails++;
            end
            if (rsp_tdata[1] !== want.status) begin
               $display("%0t status exp %0d got %0d", $time, want.status, rsp_tdata[1]);
               fails++;
            end
            if (rsp_tdata[33:2] !== want.count) begin
               $display("%0t items_added exp %0d got %0d", $time, want.count, rsp_tdata[33:2]);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout, %0d responses outstanding", $time, answer_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      foreach (store_bits[i]) store_bits[i] = '0;
      key_len = 0;
      key_ovf = 1'b0;
      add_total = '0;
      cfg_words = 7'd64;
      cfg_probes = 4'd1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(200);
      wait_drained();
      repeat (200) @(posedge clock);
      if (answer_q.size() != 0) fails++;
      $display("%0d requests in %0d keys, %0d responses: %0d query hits, %0d rejected keys",
               chunks_sent, keys_sent, answers_seen, hits, rejects);
      $display("filter sizes 1..64 words and 1..8 probes with out-of-range values, four flow modes");
      if (fails == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
